[sv/stw_pkg.sv]
// Shared types and constants for the stale tip watchdog.
`timescale 1ns / 1ps

package stw_pkg;

  localparam int TIME_BITS_DEF = 40;
  localparam int THR_W         = 40;
  localparam int BINT_W        = 20;
  localparam int HEIGHT_IN_W   = 31;
  localparam int HEIGHT_W      = 32;
  localparam int COUNT_W       = 16;
  localparam int SEC_W         = 40;
  localparam int MISSED_W      = 32;
  localparam int CFG_IDX_W     = 2;
  localparam int QUEUE_DEPTH   = 2;

  localparam logic [THR_W-1:0]    STALE_THRESHOLD_RST = THR_W'(1800);
  localparam logic [THR_W-1:0]    CHECK_SPACING_RST   = THR_W'(300);
  localparam logic [BINT_W-1:0]   BLOCK_SPACING_RST   = BINT_W'(600);
  localparam logic [HEIGHT_W-1:0] HEIGHT_NONE         = '1;
  localparam logic [COUNT_W-1:0]  COUNT_MAX           = '1;

  typedef enum logic [1:0] {
    CMD_CHAIN_UPDATE = 2'd0,
    CMD_BLOCK        = 2'd1,
    CMD_CHECK        = 2'd2,
    CMD_CLEAR        = 2'd3
  } stw_cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STALE_THRESHOLD = 2'd0,
    REG_CHECK_SPACING   = 2'd1,
    REG_BLOCK_SPACING   = 2'd2
  } stw_reg_t;

  typedef struct packed {
    logic               stale;
    logic               fired;
    logic [COUNT_W-1:0] count;
  } stw_flags_t;

  localparam int FLAGS_W = $bits(stw_flags_t);

endpackage

[sv/stw_queue.sv]
// Small flop-based FIFO between the front and back parts.
`timescale 1ns / 1ps

module stw_queue
  import stw_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    fill;
  logic             do_push;
  logic             do_pop;

  assign push_ready = fill != CW'(DEPTH);
  assign pop_valid  = fill != '0;
  assign pop_data   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

[sv/stw_front.sv]
// Front part: accepts events, updates watchdog state, classifies staleness.
`timescale 1ns / 1ps

module stw_front
  import stw_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             cmd,
  input  logic [TIME_BITS-1:0]   now,
  input  logic [HEIGHT_IN_W-1:0] new_height,
  input  logic [TIME_BITS-1:0]   header_time,
  input  logic [THR_W-1:0]       stale_threshold,
  input  logic [THR_W-1:0]       check_spacing,
  output logic                   push_valid,
  input  logic                   push_ready,
  output stw_flags_t             push_flags,
  output logic [TIME_BITS-1:0]   push_elapsed
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_PUSH
  } state_t;

  state_t                 state;
  stw_cmd_t               cmd_q;
  logic [TIME_BITS-1:0]   now_q;
  logic [HEIGHT_IN_W-1:0] height_q;
  logic [TIME_BITS-1:0]   tip_q;
  logic                   fired;

  logic [TIME_BITS-1:0]   last_block_time;
  logic [TIME_BITS-1:0]   stored_tip_time;
  logic [HEIGHT_W-1:0]    stored_height;
  logic [TIME_BITS-1:0]   last_check_time;
  logic [COUNT_W-1:0]     stale_counter;

  logic [TIME_BITS:0]     since;
  logic [TIME_BITS:0]     age;
  logic [TIME_BITS:0]     chk_diff;
  logic                   since_gt;
  logic                   age_gt;
  logic                   stale_now;
  logic                   limited;
  logic                   advanced;

  // signed differences, one extra bit for the sign
  assign since    = {1'b0, now_q} - {1'b0, last_block_time};
  assign age      = {1'b0, now_q} - {1'b0, stored_tip_time};
  assign chk_diff = {1'b0, now_q} - {1'b0, last_check_time};

  assign since_gt  = !since[TIME_BITS] && (64'(since[TIME_BITS-1:0]) > 64'(stale_threshold));
  assign age_gt    = !age[TIME_BITS] && (64'(age[TIME_BITS-1:0]) > 64'(stale_threshold));
  assign stale_now = !stored_height[HEIGHT_W-1] && (last_block_time != '0) && since_gt && age_gt;
  assign limited   = (last_check_time != '0) &&
                     (chk_diff[TIME_BITS] ||
                      (64'(chk_diff[TIME_BITS-1:0]) < 64'(check_spacing)));
  assign advanced  = $signed({1'b0, height_q}) > $signed(stored_height);

  assign in_ready         = state == ST_IDLE;
  assign push_valid       = state == ST_PUSH;
  assign push_flags.stale = stale_now;
  assign push_flags.fired = fired;
  assign push_flags.count = stale_counter;
  assign push_elapsed     = ((last_block_time == '0) || since[TIME_BITS] || (since == '0))
                            ? '0 : since[TIME_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      fired           <= 1'b0;
      last_block_time <= '0;
      stored_tip_time <= '0;
      stored_height   <= HEIGHT_NONE;
      last_check_time <= '0;
      stale_counter   <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            cmd_q    <= stw_cmd_t'(cmd);
            now_q    <= now;
            height_q <= new_height;
            tip_q    <= header_time;
            state    <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          fired <= 1'b0;
          case (cmd_q)
            CMD_CHAIN_UPDATE: begin
              stored_height   <= HEIGHT_W'(height_q);
              stored_tip_time <= tip_q;
              if (last_block_time == '0 || advanced) begin
                last_block_time <= now_q;
              end
              if (advanced) begin
                stale_counter <= '0;
              end
            end
            CMD_BLOCK: begin
              last_block_time <= now_q;
              stale_counter   <= '0;
            end
            CMD_CHECK: begin
              if (stale_now && !limited) begin
                last_check_time <= now_q;
                fired           <= 1'b1;
                if (stale_counter != COUNT_MAX) begin
                  stale_counter <= stale_counter + 1'b1;
                end
              end
            end
            default: begin
              last_block_time <= '0;
              stored_tip_time <= '0;
              stored_height   <= HEIGHT_NONE;
              last_check_time <= '0;
              stale_counter   <= '0;
            end
          endcase
          state <= ST_PUSH;
        end
        ST_PUSH: begin
          if (push_ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

[sv/stw_back.sv]
// Back part: radix-2 divider for the missed block estimate and the result register.
`timescale 1ns / 1ps

module stw_back
  import stw_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 pop_valid,
  output logic                 pop_ready,
  input  stw_flags_t           pop_flags,
  input  logic [TIME_BITS-1:0] pop_elapsed,
  input  logic [BINT_W-1:0]    block_spacing,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 stale,
  output logic                 more_peers_needed,
  output logic [COUNT_W-1:0]   stale_count,
  output logic [SEC_W-1:0]     seconds_since_block,
  output logic [MISSED_W-1:0]  missed_blocks
);

  localparam int SW = $clog2(TIME_BITS + 1);

  typedef enum logic [1:0] {
    B_IDLE,
    B_DIV,
    B_OUT
  } state_t;

  state_t               state;
  logic [SW-1:0]        step;
  logic [TIME_BITS-1:0] dq;
  logic [BINT_W-1:0]    rem;

  logic [BINT_W:0]      rem_shift;
  logic                 ge;
  logic [BINT_W-1:0]    rem_next;
  logic [TIME_BITS-1:0] dq_next;
  logic [63:0]          q_ext;
  logic [63:0]          e_ext;

  assign rem_shift = {rem, dq[TIME_BITS-1]};
  assign ge        = rem_shift >= {1'b0, block_spacing};
  assign rem_next  = ge ? BINT_W'(rem_shift - {1'b0, block_spacing}) : rem_shift[BINT_W-1:0];
  assign dq_next   = {dq[TIME_BITS-2:0], ge};
  assign q_ext     = 64'(dq_next);
  assign e_ext     = 64'(pop_elapsed);

  assign pop_ready = state == B_IDLE;
  assign out_valid = state == B_OUT;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      step  <= '0;
    end else begin
      case (state)
        B_IDLE: begin
          if (pop_valid) begin
            stale               <= pop_flags.stale;
            more_peers_needed   <= pop_flags.fired;
            stale_count         <= pop_flags.count;
            seconds_since_block <= (|e_ext[63:SEC_W]) ? '1 : e_ext[SEC_W-1:0];
            dq                  <= pop_elapsed;
            rem                 <= '0;
            step                <= SW'(TIME_BITS);
            if (block_spacing == '0 || pop_elapsed == '0) begin
              missed_blocks <= '0;
              state         <= B_OUT;
            end else begin
              state <= B_DIV;
            end
          end
        end
        B_DIV: begin
          dq   <= dq_next;
          rem  <= rem_next;
          step <= step - 1'b1;
          if (step == SW'(1)) begin
            missed_blocks <= (|q_ext[63:MISSED_W]) ? '1 : q_ext[MISSED_W-1:0];
            state         <= B_OUT;
          end
        end
        B_OUT: begin
          if (out_ready) begin
            state <= B_IDLE;
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

endmodule

[sv/stale_tip_watchdog_top.sv]
// Stale tip watchdog top level: configuration registers, front, queue and back.
// The back part divides the elapsed time by the block interval one quotient bit per
// cycle and takes no new result until the current one is taken at the output; a zero
// interval or zero elapsed skips the divide. The front part handles one event at a
// time: accept, state update, then classify and push, waiting while the queue is full.
// Synchronous reset returns watchdog state and registers to defaults at once.
`timescale 1ns / 1ps

module stale_tip_watchdog_top
  import stw_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             cmd,
  input  logic [TIME_BITS-1:0]   now,
  input  logic [HEIGHT_IN_W-1:0] new_height,
  input  logic [TIME_BITS-1:0]   header_time,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   stale,
  output logic                   more_peers_needed,
  output logic [COUNT_W-1:0]     stale_count,
  output logic [SEC_W-1:0]       seconds_since_block,
  output logic [MISSED_W-1:0]    missed_blocks,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [THR_W-1:0]       cfg_data
);

  localparam int QW = FLAGS_W + TIME_BITS;

  logic [THR_W-1:0]     stale_threshold;
  logic [THR_W-1:0]     check_spacing;
  logic [BINT_W-1:0]    block_spacing;

  logic                 push_valid;
  logic                 push_ready;
  stw_flags_t           push_flags;
  logic [TIME_BITS-1:0] push_elapsed;
  logic                 pop_valid;
  logic                 pop_ready;
  logic [QW-1:0]        pop_data;
  stw_flags_t           pop_flags;
  logic [TIME_BITS-1:0] pop_elapsed;

  always_ff @(posedge clk) begin
    if (rst) begin
      stale_threshold <= STALE_THRESHOLD_RST;
      check_spacing   <= CHECK_SPACING_RST;
      block_spacing   <= BLOCK_SPACING_RST;
    end else if (cfg_we) begin
      case (stw_reg_t'(cfg_index))
        REG_STALE_THRESHOLD: stale_threshold <= cfg_data;
        REG_CHECK_SPACING:   check_spacing   <= cfg_data;
        REG_BLOCK_SPACING:   block_spacing   <= cfg_data[BINT_W-1:0];
        default: ;
      endcase
    end
  end

  stw_front #(
    .TIME_BITS(TIME_BITS)
  ) u_front (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .cmd             (cmd),
    .now             (now),
    .new_height      (new_height),
    .header_time     (header_time),
    .stale_threshold (stale_threshold),
    .check_spacing   (check_spacing),
    .push_valid      (push_valid),
    .push_ready      (push_ready),
    .push_flags      (push_flags),
    .push_elapsed    (push_elapsed)
  );

  stw_queue #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  ({push_flags, push_elapsed}),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  assign pop_flags   = pop_data[QW-1:TIME_BITS];
  assign pop_elapsed = pop_data[TIME_BITS-1:0];

  stw_back #(
    .TIME_BITS(TIME_BITS)
  ) u_back (
    .clk                 (clk),
    .rst                 (rst),
    .pop_valid           (pop_valid),
    .pop_ready           (pop_ready),
    .pop_flags           (pop_flags),
    .pop_elapsed         (pop_elapsed),
    .block_spacing       (block_spacing),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .stale               (stale),
    .more_peers_needed   (more_peers_needed),
    .stale_count         (stale_count),
    .seconds_since_block (seconds_since_block),
    .missed_blocks       (missed_blocks)
  );

endmodule

[sv/stw_checker.sv]
// Port-level checks for the stale tip watchdog, bound to the top level.
`timescale 1ns / 1ps

module stw_checker
  import stw_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                out_valid,
  input logic                out_ready,
  input logic                stale,
  input logic                more_peers_needed,
  input logic [COUNT_W-1:0]  stale_count,
  input logic [SEC_W-1:0]    seconds_since_block,
  input logic [MISSED_W-1:0] missed_blocks
);

  a_rst_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(stale_count) &&
    $stable(seconds_since_block) && $stable(missed_blocks))
    else $error("stalled result changed");

  a_fire_stale: assert property (@(posedge clk) disable iff (rst)
    out_valid && more_peers_needed |-> stale)
    else $error("check fired without staleness");

  a_stale_elapsed: assert property (@(posedge clk) disable iff (rst)
    out_valid && stale |-> seconds_since_block != '0)
    else $error("stale with zero elapsed time");

  a_missed_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && seconds_since_block == '0 |-> missed_blocks == '0)
    else $error("missed blocks without elapsed time");

endmodule

bind stale_tip_watchdog_top stw_checker u_stw_checker (.*);
